/* hdl/jbe_pkg.sv */
// Shared types and constants of the JPEG block entropy encoder.
// No dependencies; every other file in hdl/ but jbe_ram imports this package.
package jbe_pkg;

    localparam int COEF_BITS     = 12;
    localparam int DIFF_BITS     = COEF_BITS + 1;
    localparam int CAT_BITS      = 4;
    localparam int BLOCK_COEFFS  = 64;
    localparam int POS_BITS      = $clog2(BLOCK_COEFFS);
    localparam int TABLE_ENTRIES = 256;
    localparam int TAB_ADDR_BITS = $clog2(TABLE_ENTRIES);
    localparam int CODE_BITS     = 16;
    localparam int LEN_BITS      = 5;
    localparam int ENTRY_BITS    = CODE_BITS + LEN_BITS;
    localparam int RUN_BITS      = POS_BITS;
    localparam int ZRL_CNT_BITS  = RUN_BITS - 4;

    localparam logic [POS_BITS-1:0]      LAST_POS = POS_BITS'(BLOCK_COEFFS - 1);
    localparam logic [TAB_ADDR_BITS-1:0] SYM_EOB  = 8'h00;
    localparam logic [TAB_ADDR_BITS-1:0] SYM_ZRL  = 8'hF0;

    // input kind codes; the fourth code is ignored
    localparam logic [1:0] KIND_COEF    = 2'd0;
    localparam logic [1:0] KIND_LOAD_DC = 2'd1;
    localparam logic [1:0] KIND_LOAD_AC = 2'd2;

    typedef enum logic [2:0] {
        OP_DC,
        OP_AC,
        OP_EOB,
        OP_LOAD_DC,
        OP_LOAD_AC
    } t_op;

    typedef struct packed {
        logic [1:0]                  kind;
        logic signed [COEF_BITS-1:0] coefficient;
        logic [TAB_ADDR_BITS-1:0]    table_index;
        logic [CODE_BITS-1:0]        table_code;
        logic [LEN_BITS-1:0]         table_length;
    } t_in_item;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_bits;
        logic [LEN_BITS-1:0]  code_length;
        logic [COEF_BITS-1:0] extra_bits;
        logic [CAT_BITS-1:0]  extra_length;
        logic                 block_end;
        logic                 last;
    } t_out_item;

    // after the state update: value to code and symbol context
    typedef struct packed {
        t_op                         op;
        logic signed [DIFF_BITS-1:0] value;
        logic [3:0]                  run;
        logic [ZRL_CNT_BITS-1:0]     nzrl;
        logic                        bend;
        logic [TAB_ADDR_BITS-1:0]    index;
        logic [ENTRY_BITS-1:0]       entry;
    } t_s1;

    // after the amplitude coder: table address and amplitude bits
    typedef struct packed {
        t_op                      op;
        logic [TAB_ADDR_BITS-1:0] addr;
        logic [ENTRY_BITS-1:0]    entry;
        logic [COEF_BITS-1:0]     xbits;
        logic [CAT_BITS-1:0]      xlen;
        logic [ZRL_CNT_BITS-1:0]  nzrl;
        logic                     bend;
    } t_s2;

endpackage

/* hdl/jbe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module jbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/jbe_front.sv */
// Input stage: block position, zero run and DC predictor; forms the DC difference.
// Depends on jbe_pkg.
module jbe_front import jbe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s1      o_s1
);

    logic                          r_valid;
    t_s1                           r_s1;
    logic [POS_BITS-1:0]           r_pos;
    logic [RUN_BITS-1:0]           r_run;
    logic signed [COEF_BITS-1:0]   r_pred;

    logic                          n_emit;
    t_s1                           n_s1;
    logic [POS_BITS-1:0]           n_pos;
    logic [RUN_BITS-1:0]           n_run;
    logic signed [COEF_BITS-1:0]   n_pred;
    logic                          in_acc;
    logic                          bend;
    logic signed [DIFF_BITS-1:0]   coef_ext;
    logic signed [DIFF_BITS-1:0]   pred_ext;

    assign o_ready = !r_valid || i_ready;
    assign in_acc  = i_valid && o_ready;
    assign bend    = (r_pos == LAST_POS);

    always_comb begin
        coef_ext   = DIFF_BITS'(i_item.coefficient);
        pred_ext   = DIFF_BITS'(r_pred);
        n_emit     = 1'b0;
        n_pos      = r_pos;
        n_run      = r_run;
        n_pred     = r_pred;
        n_s1.op    = OP_LOAD_DC;
        n_s1.value = '0;
        n_s1.run   = '0;
        n_s1.nzrl  = '0;
        n_s1.bend  = bend;
        n_s1.index = i_item.table_index;
        n_s1.entry = {i_item.table_length, i_item.table_code};
        unique case (i_item.kind)
            KIND_LOAD_DC: begin
                n_emit  = 1'b1;
                n_s1.op = OP_LOAD_DC;
            end
            KIND_LOAD_AC: begin
                n_emit  = 1'b1;
                n_s1.op = OP_LOAD_AC;
            end
            KIND_COEF: begin
                if (r_pos == '0) begin
                    n_emit     = 1'b1;
                    n_s1.op    = OP_DC;
                    n_s1.value = coef_ext - pred_ext;
                    n_pred     = i_item.coefficient;
                end else if (i_item.coefficient == '0) begin
                    // zeros only count; the block's last zero closes with EOB
                    n_emit  = bend;
                    n_s1.op = OP_EOB;
                    n_run   = r_run + 1'b1;
                end else begin
                    n_emit     = 1'b1;
                    n_s1.op    = OP_AC;
                    n_s1.value = coef_ext;
                    n_s1.run   = r_run[3:0];
                    n_s1.nzrl  = r_run[RUN_BITS-1:4];
                    n_run      = '0;
                end
                if (bend) begin
                    n_pos = '0;
                    n_run = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
            r_run   <= '0;
            r_pred  <= '0;
        end else begin
            if (in_acc) begin
                r_valid <= n_emit;
                r_pos   <= n_pos;
                r_run   <= n_run;
                r_pred  <= n_pred;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

/* hdl/jbe_amp.sv */
// Amplitude stage: size category, ones-complement amplitude bits, table address.
// Depends on jbe_pkg.
module jbe_amp import jbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_s1,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_s2
);

    logic                      r_valid;
    t_s2                       r_s2;
    t_s2                       n_s2;
    logic                      in_acc;
    logic                      neg;
    logic [COEF_BITS-1:0]      mag;
    logic [CAT_BITS-1:0]       cat;
    logic [COEF_BITS-1:0]      mask;
    logic [DIFF_BITS-1:0]      raw;

    assign o_ready = !r_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        neg = i_s1.value[DIFF_BITS-1];
        mag = neg ? COEF_BITS'(-i_s1.value) : COEF_BITS'(i_s1.value);
        cat = '0;
        for (int i = 0; i < COEF_BITS; i++) begin
            if (mag[i]) begin
                cat = CAT_BITS'(i + 1);
            end
        end
        mask = COEF_BITS'((DIFF_BITS'(1) << cat) - DIFF_BITS'(1));
        raw  = neg ? DIFF_BITS'(i_s1.value - DIFF_BITS'(1)) : DIFF_BITS'(i_s1.value);

        n_s2.op    = i_s1.op;
        n_s2.entry = i_s1.entry;
        n_s2.xbits = raw[COEF_BITS-1:0] & mask;
        n_s2.xlen  = cat;
        n_s2.nzrl  = i_s1.nzrl;
        n_s2.bend  = i_s1.bend;
        unique case (i_s1.op)
            OP_DC:   n_s2.addr = TAB_ADDR_BITS'(cat);
            OP_AC:   n_s2.addr = {i_s1.run, cat};
            OP_EOB:  n_s2.addr = SYM_EOB;
            default: n_s2.addr = i_s1.index;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

/* hdl/jbe_emit.sv */
// Table stage and output register: code tables, ZRL entry copy, symbol emission.
// Depends on jbe_pkg and jbe_ram.
module jbe_emit import jbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_s2       i_s2,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic                     r_valid;
    logic                     r_is_dc;
    logic [COEF_BITS-1:0]     r_xbits;
    logic [CAT_BITS-1:0]      r_xlen;
    logic [ZRL_CNT_BITS-1:0]  r_cnt;
    logic                     r_bend;
    logic [ENTRY_BITS-1:0]    r_zrl_entry;
    logic [ENTRY_BITS-1:0]    r_zrl_snap;

    logic                     is_load;
    logic                     in_acc;
    logic                     out_acc;
    logic                     done;
    logic                     rd_en;
    logic                     dc_we;
    logic                     ac_we;
    logic [ENTRY_BITS-1:0]    dc_q;
    logic [ENTRY_BITS-1:0]    ac_q;
    logic [ENTRY_BITS-1:0]    sym_entry;

    assign is_load = (i_s2.op == OP_LOAD_DC) || (i_s2.op == OP_LOAD_AC);
    assign out_acc = r_valid && i_ready;
    assign done    = out_acc && (r_cnt == '0);
    // loads write in order with reads here and never occupy the output register
    assign o_ready = is_load || !r_valid || done;
    assign in_acc  = i_valid && o_ready;
    assign rd_en   = in_acc && !is_load;
    assign dc_we   = in_acc && (i_s2.op == OP_LOAD_DC);
    assign ac_we   = in_acc && (i_s2.op == OP_LOAD_AC);

    jbe_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_dc_ram (
        .i_clk   (i_clk),
        .i_we    (dc_we),
        .i_waddr (i_s2.addr),
        .i_wdata (i_s2.entry),
        .i_re    (rd_en),
        .i_raddr (i_s2.addr),
        .o_rdata (dc_q)
    );

    jbe_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_ac_ram (
        .i_clk   (i_clk),
        .i_we    (ac_we),
        .i_waddr (i_s2.addr),
        .i_wdata (i_s2.entry),
        .i_re    (rd_en),
        .i_raddr (i_s2.addr),
        .o_rdata (ac_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (rd_en) begin
                r_valid <= 1'b1;
                r_cnt   <= i_s2.nzrl;
            end else if (done) begin
                r_valid <= 1'b0;
            end else if (out_acc) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ac_we && (i_s2.addr == SYM_ZRL)) begin
            r_zrl_entry <= i_s2.entry;
        end
        if (rd_en) begin
            r_is_dc    <= (i_s2.op == OP_DC);
            r_xbits    <= i_s2.xbits;
            r_xlen     <= i_s2.xlen;
            r_bend     <= i_s2.bend;
            r_zrl_snap <= r_zrl_entry;
        end
    end

    assign sym_entry = r_is_dc ? dc_q : ac_q;

    always_comb begin
        if (r_cnt != '0) begin
            o_item.code_bits    = r_zrl_snap[CODE_BITS-1:0];
            o_item.code_length  = r_zrl_snap[ENTRY_BITS-1:CODE_BITS];
            o_item.extra_bits   = '0;
            o_item.extra_length = '0;
            o_item.block_end    = 1'b0;
            o_item.last         = 1'b0;
        end else begin
            o_item.code_bits    = sym_entry[CODE_BITS-1:0];
            o_item.code_length  = sym_entry[ENTRY_BITS-1:CODE_BITS];
            o_item.extra_bits   = r_xbits;
            o_item.extra_length = r_xlen;
            o_item.block_end    = r_bend;
            o_item.last         = 1'b1;
        end
    end

    assign o_valid = r_valid;

endmodule

/* hdl/jpeg_block_entropy_encoder.sv */
// JPEG baseline Huffman block encoder, symbol level: top level and checks.
// Depends on jbe_pkg, jbe_front, jbe_amp, jbe_emit (and jbe_ram below it).
//
// Usage:
//   Input channel (i_valid / o_ready, payload i_item): each item is either a
//   table load (DC or AC code entry) or one quantized coefficient of the
//   current block in zigzag order. Position 0 of a block is DC, 1..63 AC.
//   Output channel (o_valid / i_ready, payload o_item): one Huffman symbol
//   per item, code word plus amplitude bits; last marks the final symbol of
//   an input item, block_end the final symbol of a block.
//   Each symbol passes the front, amplitude and table read stages, each
//   registered, and then waits in the output register until it is taken.
//   Throughput: one input item per cycle while the receiver takes symbols.
//   A nonzero AC coefficient after 16 or more zeros holds the output
//   register through its ZRLs (up to three), backing up the two stages ahead.
//   Tables live in two 256x21 RAMs; loads pass down the pipeline and write
//   where reads are issued, so reads and writes always stay in item order.
//   Reset clears block position, zero run, DC predictor and all valid bits;
//   table contents are left as they are and must be loaded before use.
//   When the receiver stalls, the output item holds and the front stages
//   keep taking items until they fill, then o_ready drops.
module jpeg_block_entropy_encoder import jbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // front -> amplitude stage
    logic s1_valid;
    logic s1_ready;
    t_s1  s1;

    // amplitude stage -> table/output stage
    logic s2_valid;
    logic s2_ready;
    t_s2  s2;

    jbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_s1    (s1)
    );

    jbe_amp u_amp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    jbe_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // only ZRL symbols come before the last symbol of an item
    a_zrl_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last |-> o_item.extra_length == '0 && !o_item.block_end)
        else $error("non-final symbol is not a ZRL");

    // block end only on the final symbol of an item
    a_bend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.block_end |-> o_item.last)
        else $error("block_end without last");

    // amplitude bits stay inside their length
    a_extra_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.extra_bits >> o_item.extra_length) == '0)
        else $error("amplitude bits exceed extra_length");

    // a load in the amplitude stage never waits on the output register
    a_load_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && (s2.op == OP_LOAD_DC || s2.op == OP_LOAD_AC) |-> s2_ready)
        else $error("table load stalled");

endmodule

/* sim/jbe_checker.sv */
// Checker for the JPEG block entropy encoder: watches both channels,
// predicts the Huffman symbols of every accepted item and compares them.
// Depends on jbe_pkg for the item types and table constants.
module jbe_checker import jbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_sym_count,
    output int        o_block_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_MAX = 15;    // longest run a run/size symbol can carry
    localparam int ZRL_RUN = 16;    // zeros covered by one ZRL

    logic [ENTRY_BITS-1:0]       dc_code_tab [TABLE_ENTRIES];
    logic [ENTRY_BITS-1:0]       ac_code_tab [TABLE_ENTRIES];
    logic signed [COEF_BITS-1:0] dc_pred   = '0;
    logic [POS_BITS-1:0]         blk_pos   = '0;
    int                          zero_cnt  = 0;
    t_out_item                   expected_syms [$];

    // symbols produced by the item being encoded, before "last" is marked
    t_out_item new_syms [4];
    int        n_new     = 0;

    int fail_cnt  = 0;
    int sym_cnt   = 0;
    int block_cnt = 0;

    // size category and amplitude bits (ones complement when negative)
    task automatic amplitude_code(input int v, output logic [COEF_BITS-1:0] bits,
                                  output logic [CAT_BITS-1:0] len);
        int mag;
        int n;
        int raw;
        mag = (v < 0) ? -v : v;
        n   = 0;
        while (mag != 0) begin
            n++;
            mag = mag >> 1;
        end
        raw  = (v < 0) ? v - 1 : v;
        len  = CAT_BITS'(n);
        bits = COEF_BITS'(raw & ((1 << n) - 1));
    endtask

    task automatic emit_sym(input logic [ENTRY_BITS-1:0] entry,
                            input logic [COEF_BITS-1:0] xbits,
                            input logic [CAT_BITS-1:0] xlen, input logic bend);
        t_out_item s;
        s.code_bits    = entry[CODE_BITS-1:0];
        s.code_length  = entry[ENTRY_BITS-1:CODE_BITS];
        s.extra_bits   = xbits;
        s.extra_length = xlen;
        s.block_end    = bend;
        s.last         = 1'b0;
        new_syms[n_new] = s;
        n_new++;
    endtask

    task automatic encode_item(input t_in_item it);
        int                   c;
        int                   pv;
        int                   d;
        logic [COEF_BITS-1:0] xb;
        logic [CAT_BITS-1:0]  xl;
        logic                 bend;
        n_new = 0;
        case (it.kind)
            KIND_LOAD_DC: dc_code_tab[it.table_index] = {it.table_length, it.table_code};
            KIND_LOAD_AC: ac_code_tab[it.table_index] = {it.table_length, it.table_code};
            KIND_COEF: begin
                c    = $signed(it.coefficient);
                pv   = $signed(dc_pred);
                bend = (blk_pos == LAST_POS);
                xb   = '0;
                xl   = '0;
                if (blk_pos == '0) begin
                    d = c - pv;
                    if (d != 0) amplitude_code(d, xb, xl);
                    emit_sym(dc_code_tab[xl], xb, xl, bend);
                    dc_pred = it.coefficient;
                end else if (c == 0) begin
                    zero_cnt++;
                    if (bend) emit_sym(ac_code_tab[SYM_EOB], '0, '0, 1'b1);
                end else begin
                    while (zero_cnt > RUN_MAX) begin
                        emit_sym(ac_code_tab[SYM_ZRL], '0, '0, 1'b0);
                        zero_cnt -= ZRL_RUN;
                    end
                    amplitude_code(c, xb, xl);
                    emit_sym(ac_code_tab[{4'(zero_cnt), xl}], xb, xl, bend);
                    zero_cnt = 0;
                end
                if (bend) begin
                    blk_pos  = '0;
                    zero_cnt = 0;
                    block_cnt++;
                end else begin
                    blk_pos++;
                end
            end
            default: ;  // unused kind: no effect
        endcase
        for (int i = 0; i < n_new; i++) begin
            if (i == n_new - 1) new_syms[i].last = 1'b1;
            expected_syms.push_back(new_syms[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            dc_pred  = '0;
            blk_pos  = '0;
            zero_cnt = 0;
            expected_syms.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                sym_cnt++;
                if (expected_syms.size() == 0) begin
                    $display("%0t: unexpected symbol: expected none, actual 0x%0h",
                             $time, i_out_item);
                    fail_cnt++;
                end else begin
                    want = expected_syms.pop_front();
                    check_field("code_bits", 32'(want.code_bits),
                                32'(i_out_item.code_bits));
                    check_field("code_length", 32'(want.code_length),
                                32'(i_out_item.code_length));
                    check_field("extra_bits", 32'(want.extra_bits),
                                32'(i_out_item.extra_bits));
                    check_field("extra_length", 32'(want.extra_length),
                                32'(i_out_item.extra_length));
                    check_field("block_end", 32'(want.block_end),
                                32'(i_out_item.block_end));
                    check_field("last", 32'(want.last), 32'(i_out_item.last));
                end
            end
            if (i_in_valid && i_in_ready) encode_item(i_in_item);
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= expected_syms.size();
        o_sym_count   <= sym_cnt;
        o_block_count <= block_cnt;
    end

endmodule

/* sim/tb_jpeg_block_entropy_encoder.sv */
// Testbench top for the JPEG block entropy encoder: builds the item stream,
// drives both handshakes with random idling and gives the verdict.
// Depends on jbe_pkg, jbe_checker and the block under test.
module tb_jpeg_block_entropy_encoder;
    import jbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 20;      // pipeline depth plus ZRL hold, with margin
    localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
    localparam int IN_W         = $bits(t_in_item);
    localparam int COEF_MAX     = 2047;
    localparam int COEF_MIN     = -2048;
    localparam int DC_CAT_MAX   = 12;

    // the fourth kind code has no meaning and must be ignored
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // shapes of random blocks
    typedef enum int {
        SHAPE_DENSE,    // about half the AC terms nonzero
        SHAPE_SPARSE,   // short zero runs
        SHAPE_RUNS,     // long zero runs, ZRLs likely
        SHAPE_EMPTY,    // all AC zero: only EOB, owed ZRLs dropped
        SHAPE_TAIL      // 62 zeros then a nonzero last term: three ZRLs
    } t_shape;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_item;

    int chk_fails;
    int chk_pending;
    int chk_syms;
    int chk_blocks;

    // item stream, built before reset is released
    t_in_item stim_q [$];
    int       gen_pos    = 0;   // block position the next coefficient lands on
    int       gen_run    = 0;   // zeros counted so far in the block being built
    int       gen_pred   = 0;   // DC predictor as the stream leaves it
    int       last_dc    = 0;
    int       coef_cnt   = 0;
    int       load_cnt   = 0;
    int       ignore_cnt = 0;
    int       cycle_cnt  = 0;

    // table entries that already hold a code in the stream built so far
    bit dc_loaded [TABLE_ENTRIES];
    bit ac_loaded [TABLE_ENTRIES];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    jpeg_block_entropy_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    jbe_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_item     (i_item),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_item    (o_item),
        .o_fail_count  (chk_fails),
        .o_pending     (chk_pending),
        .o_sym_count   (chk_syms),
        .o_block_count (chk_blocks)
    );

    // ------------------------------------------------------------------
    // Stream construction
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(input logic [1:0] kind, input int coef,
                                           input int idx, input int code, input int len);
        t_in_item it;
        it.kind         = kind;
        it.coefficient  = COEF_BITS'(coef);
        it.table_index  = TAB_ADDR_BITS'(idx);
        it.table_code   = CODE_BITS'(code);
        it.table_length = LEN_BITS'(len);
        return it;
    endfunction

    task automatic push_item(input logic [1:0] kind, input int coef, input int idx,
                             input int code, input int len);
        stim_q.push_back(make_item(kind, coef, idx, code, len));
        case (kind)
            KIND_COEF: begin
                coef_cnt++;
                gen_pos = (gen_pos + 1) % BLOCK_COEFFS;
            end
            KIND_LOAD_DC: begin
                load_cnt++;
                dc_loaded[TAB_ADDR_BITS'(idx)] = 1'b1;
            end
            KIND_LOAD_AC: begin
                load_cnt++;
                ac_loaded[TAB_ADDR_BITS'(idx)] = 1'b1;
            end
            default: ignore_cnt++;
        endcase
    endtask

    // mostly legal code lengths, now and then one above 16
    function automatic int rand_len();
        if ($urandom_range(0, 7) == 0) return $urandom_range(17, 31);
        return $urandom_range(0, 16);
    endfunction

    // size category of a value
    function automatic int cat_of(input int v);
        int mag;
        int n;
        mag = (v < 0) ? -v : v;
        n   = 0;
        while (mag != 0) begin
            n++;
            mag = mag >> 1;
        end
        return n;
    endfunction

    // load an entry just before its first read
    task automatic need_dc(input int idx);
        if (!dc_loaded[TAB_ADDR_BITS'(idx)])
            push_item(KIND_LOAD_DC, $urandom, idx, $urandom, rand_len());
    endtask

    task automatic need_ac(input int idx);
        if (!ac_loaded[TAB_ADDR_BITS'(idx)])
            push_item(KIND_LOAD_AC, $urandom, idx, $urandom, rand_len());
    endtask

    // coefficient items carry random junk in the table fields; every entry the
    // coefficient reads gets a code first
    task automatic push_coef(input int c);
        if (gen_pos == 0) begin
            need_dc(cat_of(c - gen_pred));
            gen_pred = c;
        end else if (c == 0) begin
            gen_run++;
            if (gen_pos == BLOCK_COEFFS - 1) need_ac(SYM_EOB);
        end else begin
            if (gen_run > 15) need_ac(SYM_ZRL);
            need_ac((gen_run % 16) * 16 + cat_of(c));
            gen_run = 0;
        end
        if (gen_pos == BLOCK_COEFFS - 1) gen_run = 0;
        push_item(KIND_COEF, c, $urandom, $urandom, $urandom);
    endtask

    function automatic int rand_full();
        return int'($urandom_range(0, 4095)) + COEF_MIN;
    endfunction

    function automatic int pick_nonzero();
        int v;
        if ($urandom_range(0, 1) == 0) begin
            v = $urandom_range(1, 15);
            return ($urandom_range(0, 1) == 0) ? v : -v;
        end
        v = rand_full();
        return (v == 0) ? 1 : v;
    endfunction

    // DC often repeats the previous one so the zero-difference symbol shows up
    function automatic int pick_dc();
        int r;
        int v;
        r = $urandom_range(0, 7);
        if (r < 2)       v = last_dc;
        else if (r == 2) v = COEF_MAX;
        else if (r == 3) v = COEF_MIN;
        else if (r < 6)  v = rand_full();
        else             v = $urandom_range(0, 40) - 20;
        last_dc = v;
        return v;
    endfunction

    // occasional table reloads and ignored items between coefficients
    task automatic maybe_noise();
        int r;
        r = $urandom_range(0, 59);
        if (r < 2)
            push_item(KIND_LOAD_DC, $urandom, $urandom_range(0, 15), $urandom, rand_len());
        else if (r < 4)
            push_item(KIND_LOAD_AC, $urandom, $urandom_range(0, 255), $urandom, rand_len());
        else if (r == 4)
            push_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endtask

    // fill from the current position to the end of the block
    task automatic gen_block(input t_shape shape);
        int odds;
        bit tail_nz;
        case (shape)
            SHAPE_DENSE:  odds = 2;
            SHAPE_SPARSE: odds = 8;
            SHAPE_RUNS:   odds = 24;
            default:      odds = 0;
        endcase
        tail_nz = (shape == SHAPE_TAIL) ||
                  (shape != SHAPE_EMPTY && $urandom_range(0, 2) == 0);
        do begin
            maybe_noise();
            if (gen_pos == 0)
                push_coef(pick_dc());
            else if (gen_pos == BLOCK_COEFFS - 1)
                push_coef(tail_nz ? pick_nonzero() : 0);
            else if (odds != 0 && $urandom_range(1, odds) == 1)
                push_coef(pick_nonzero());
            else
                push_coef(0);
        end while (gen_pos != 0);
    endtask

    task automatic build_stream();
        // directed opening: ignored kind, over-long code lengths, extremes
        push_item(KIND_UNUSED, -1, 255, 16'hFFFF, 31);
        push_item(KIND_LOAD_DC, 0, DC_CAT_MAX, 16'hFFFF, 31);  // DC category 12
        push_item(KIND_LOAD_AC, 0, 8'hF2, 16'h0000, 17);        // run 15, size 2
        push_coef(COEF_MIN);    // DC difference -2048: category 12
        last_dc = COEF_MIN;
        push_coef(COEF_MAX);
        push_coef(COEF_MIN);
        push_coef(1);
        push_coef(-1);
        for (int i = 0; i < 15; i++) push_coef(0);
        push_coef(3);           // run of exactly 15 zeros: no ZRL

        // random part: finish the open block, then dense, long-run, empty
        // and tail blocks
        gen_block(SHAPE_SPARSE);
        gen_block(SHAPE_DENSE);
        gen_block(SHAPE_RUNS);
        gen_block(SHAPE_EMPTY);
        gen_block(SHAPE_TAIL);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready runs of random length broken by stalls; short runs give
    // a choppy pattern, long ones free flow.
    // ------------------------------------------------------------------
    int rdy_run   = 0;
    int rdy_stall = 0;

    always @(posedge i_clk) begin
        if (rdy_stall > 0) begin
            rdy_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (rdy_run > 0) begin
                rdy_run--;
            end else begin
                rdy_run   = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(0, 8);
                rdy_stall = $urandom_range(1, 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any hang ends the run as a failure
    // ------------------------------------------------------------------
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d symbols still expected",
                 cycle_cnt, chk_pending);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps; payload is noise
    // while valid is low. Valid stays up and the item holds until taken.
    // ------------------------------------------------------------------
    initial begin
        int idx;
        int burst_left;
        int gap_left;

        build_stream();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx        = 0;
        burst_left = $urandom_range(1, 32);
        gap_left   = 0;
        while (idx < stim_q.size()) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
                i_item  <= IN_W'({$urandom, $urandom});
                @(posedge i_clk);
            end else begin
                i_valid <= 1'b1;
                i_item  <= stim_q[idx];
                @(posedge i_clk);
                while (!o_ready) @(posedge i_clk);
                idx++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                    // a quarter of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_valid <= 1'b0;

        // the checker's counts are registered, so they lag the last accepted item
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d coefficient items in %0d blocks, %0d table loads, %0d ignored",
                 coef_cnt, chk_blocks, load_cnt, ignore_cnt);
        $display("Checked %0d symbols, %0d mismatches, %0d symbols never seen",
                 chk_syms, chk_fails, chk_pending);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/jbe_pkg.sv
hdl/jbe_ram.sv
hdl/jbe_front.sv
hdl/jbe_amp.sv
hdl/jbe_emit.sv
hdl/jpeg_block_entropy_encoder.sv
sim/jbe_checker.sv
sim/tb_jpeg_block_entropy_encoder.sv
